/* hdl/cel_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cel_pkg: shared types and constants of the circular event log
// Ring geometry, command encoding and the decoded command that travels from
// the front end through the command queue to the back end.
// ----------------------------------------------------------------------------
package cel_pkg;

	// ring geometry
	localparam int DEPTH       = 32;
	localparam int SLOT_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);

	// port field widths
	localparam int OP_W        = 2;
	localparam int STAMP_W     = 32;
	localparam int CODE_W      = 8;
	localparam int DUR_W       = 16;
	localparam int REQ_W       = 6;
	localparam int COUNT_W     = 6;

	// most records one dump may return
	localparam int MAX_RESULTS = 32;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	// common width for the dump length arithmetic
	localparam int NUM_W0      = (CNT_W > REQ_W) ? CNT_W : REQ_W;
	localparam int NUM_W       = (NUM_W0 > RES_W) ? NUM_W0 : RES_W;

	// command queue between front and back end
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	// operation codes as seen on the op port
	localparam logic [OP_W-1:0] OPC_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OPC_READ  = 2'd1;
	localparam logic [OP_W-1:0] OPC_CLEAR = 2'd2;

	// decoded operation
	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_CLEAR,
		OP_NONE
	} op_t;

	// back end sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_READ
	} back_state_t;

	// one decoded command
	typedef struct packed {
		op_t                op;
		logic [STAMP_W-1:0] stamp;
		logic [CODE_W-1:0]  kind;
		logic [CODE_W-1:0]  outcome;
		logic [DUR_W-1:0]   duration;
		logic [CODE_W-1:0]  origin;
		logic [REQ_W-1:0]   req;
	} cmd_t;

	// queue status seen by the front end
	typedef struct packed {
		logic full;
	} q_stat_t;

endpackage : cel_pkg
`default_nettype wire

/* hdl/cel_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cel_fifo: command queue
// Short register queue of decoded commands between the front and back end.
// ----------------------------------------------------------------------------
module cel_fifo
	import cel_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire cmd_t    push_cmd,
	output q_stat_t      stat,
	input  wire logic    pop,
	output logic         not_empty,
	output cmd_t         head
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	// status
	assign stat.full = (fill_q == QCNT_W'(QDEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !stat.full;
	assign do_pop    = pop && not_empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule : cel_fifo
`default_nettype wire

/* hdl/cel_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cel_front: command intake
// Takes transactions on the start/busy handshake, decodes the op code and
// hands the decoded command to the command queue.
// ----------------------------------------------------------------------------
module cel_front
	import cel_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [OP_W-1:0]    op,
	input  wire logic [STAMP_W-1:0] event_stamp,
	input  wire logic [CODE_W-1:0]  event_kind,
	input  wire logic [CODE_W-1:0]  outcome_code,
	input  wire logic [DUR_W-1:0]   event_duration,
	input  wire logic [CODE_W-1:0]  origin_code,
	input  wire logic [REQ_W-1:0]   max_records,
	input  wire q_stat_t            q_stat,
	output logic                    push,
	output cmd_t                    push_cmd
);

	logic accept;
	logic valid_s1;
	cmd_t cmd_s1;
	op_t  op_dec;

	// op decode
	always_comb begin
		unique case (op)
			OPC_WRITE: op_dec = OP_WRITE;
			OPC_READ:  op_dec = OP_READ;
			OPC_CLEAR: op_dec = OP_CLEAR;
			default:   op_dec = OP_NONE;
		endcase
	end

	// stage holds while the queue is full
	assign busy     = valid_s1 && q_stat.full;
	assign accept   = start && !busy;
	assign push     = valid_s1 && !q_stat.full;
	assign push_cmd = cmd_s1;

	// intake stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// intake stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op       <= op_dec;
			cmd_s1.stamp    <= event_stamp;
			cmd_s1.kind     <= event_kind;
			cmd_s1.outcome  <= outcome_code;
			cmd_s1.duration <= event_duration;
			cmd_s1.origin   <= origin_code;
			cmd_s1.req      <= max_records;
		end
	end

endmodule : cel_front
`default_nettype wire

/* hdl/cel_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cel_back: record ring and dump sequencer
// Holds the record memory, write slot and count, carries out queued commands
// and drives the result strobe with registered record fields.
// ----------------------------------------------------------------------------
module cel_back
	import cel_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_not_empty,
	input  wire cmd_t                q_head,
	output logic                     pop,
	output logic                     strobe,
	output logic [STAMP_W-1:0]       out_stamp,
	output logic [CODE_W-1:0]        out_kind,
	output logic [CODE_W-1:0]        out_outcome,
	output logic [DUR_W-1:0]         out_duration,
	output logic [CODE_W-1:0]        out_origin,
	output logic                     record_valid,
	output logic                     last,
	output logic [COUNT_W-1:0]       stored_count
);

	localparam int INFO_W = 3 * CODE_W + DUR_W;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [SLOT_W-1:0]  wr_slot_q;
	logic [CNT_W-1:0]   count_q;
	logic [SLOT_W-1:0]  rd_slot_q;
	logic [NUM_W-1:0]   remain_q;

	logic [STAMP_W-1:0] stamp_mem [DEPTH];
	logic [INFO_W-1:0]  info_mem  [DEPTH];
	logic [STAMP_W-1:0] rd_stamp_q;
	logic [INFO_W-1:0]  rd_info_q;

	logic               strobe_q;
	logic               rec_valid_q;
	logic               last_q;

	logic               wr_go;
	logic               clr_go;
	logic               ack_go;
	logic               load_go;
	logic               step_go;
	logic [NUM_W-1:0]   dump_len;
	logic [NUM_W-1:0]   held_ext;
	logic [NUM_W-1:0]   req_ext;
	logic [SLOT_W-1:0]  dump_start;
	logic               ring_full;

	// dump length and first slot
	assign ring_full = (count_q == CNT_W'(DEPTH));
	assign held_ext  = NUM_W'(count_q);
	assign req_ext   = NUM_W'(q_head.req);
	always_comb begin
		dump_len = (req_ext > held_ext) ? held_ext : req_ext;
		if (dump_len > NUM_W'(MAX_RESULTS)) begin
			dump_len = NUM_W'(MAX_RESULTS);
		end
	end
	assign dump_start = ring_full ? wr_slot_q : '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_not_empty && q_head.op == OP_READ && dump_len != '0) begin
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				if (remain_q == NUM_W'(1)) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop     = 1'b0;
		wr_go   = 1'b0;
		clr_go  = 1'b0;
		ack_go  = 1'b0;
		load_go = 1'b0;
		step_go = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_not_empty) begin
					pop = 1'b1;
					unique case (q_head.op)
						OP_WRITE: begin
							wr_go  = 1'b1;
							ack_go = 1'b1;
						end
						OP_READ: begin
							if (dump_len == '0) begin
								ack_go = 1'b1;
							end else begin
								load_go = 1'b1;
							end
						end
						OP_CLEAR: begin
							clr_go = 1'b1;
							ack_go = 1'b1;
						end
						default: ack_go = 1'b1;
					endcase
				end
			end
			BK_READ: step_go = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			wr_slot_q   <= '0;
			count_q     <= '0;
			rd_slot_q   <= '0;
			remain_q    <= '0;
			strobe_q    <= 1'b0;
			rec_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_go) begin
				wr_slot_q <= (wr_slot_q == SLOT_W'(DEPTH - 1)) ? '0 : wr_slot_q + 1'b1;
				if (!ring_full) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (clr_go) begin
				wr_slot_q <= '0;
				count_q   <= '0;
			end
			if (load_go) begin
				rd_slot_q <= dump_start;
				remain_q  <= dump_len;
			end
			if (step_go) begin
				rd_slot_q <= (rd_slot_q == SLOT_W'(DEPTH - 1)) ? '0 : rd_slot_q + 1'b1;
				remain_q  <= remain_q - 1'b1;
			end
			// result strobe and flags
			strobe_q    <= ack_go || step_go;
			rec_valid_q <= step_go;
			last_q      <= ack_go || (step_go && remain_q == NUM_W'(1));
		end
	end

	// record memory write port
	always_ff @(posedge clk) begin
		if (wr_go) begin
			stamp_mem[wr_slot_q] <= q_head.stamp;
			info_mem[wr_slot_q]  <= {q_head.kind, q_head.outcome, q_head.duration,
			                         q_head.origin};
		end
	end

	// record memory read port
	always_ff @(posedge clk) begin
		if (step_go) begin
			rd_stamp_q <= stamp_mem[rd_slot_q];
			rd_info_q  <= info_mem[rd_slot_q];
		end
	end

	// result ports, record fields zero on acknowledgements
	assign strobe       = strobe_q;
	assign record_valid = rec_valid_q;
	assign last         = last_q;
	assign stored_count = COUNT_W'(count_q);
	assign out_stamp    = rec_valid_q ? rd_stamp_q : '0;
	assign out_kind     = rec_valid_q ? rd_info_q[INFO_W-1 -: CODE_W] : '0;
	assign out_outcome  = rec_valid_q ? rd_info_q[INFO_W-CODE_W-1 -: CODE_W] : '0;
	assign out_duration = rec_valid_q ? rd_info_q[CODE_W+DUR_W-1 -: DUR_W] : '0;
	assign out_origin   = rec_valid_q ? rd_info_q[CODE_W-1:0] : '0;

endmodule : cel_back
`default_nettype wire

/* hdl/circular_event_log_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_event_log_top: ring log of event records, oldest overwritten
// Write, dump-oldest-first and clear commands on a start/busy port; results
// leave on a strobe with the stored record count.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge with start high and busy low. Every
// result appears for exactly one cycle with strobe high and cannot be held
// off, so the receiver must take it then. A write, clear, unused op or empty
// dump gives one acknowledgement (record_valid low, last high) after it has
// passed the intake stage, the command queue and the result register. A dump
// of n records gives n strobes on consecutive cycles, oldest first, with last
// on the final one, and occupies the back end for a set-up step, then one
// memory read per record. A two-entry command queue and the intake stage
// let busy stay low while a dump is running; busy rises only once both fill.
// ----------------------------------------------------------------------------
module circular_event_log_top
	import cel_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [OP_W-1:0]    op,
	input  wire logic [STAMP_W-1:0] event_stamp,
	input  wire logic [CODE_W-1:0]  event_kind,
	input  wire logic [CODE_W-1:0]  outcome_code,
	input  wire logic [DUR_W-1:0]   event_duration,
	input  wire logic [CODE_W-1:0]  origin_code,
	input  wire logic [REQ_W-1:0]   max_records,
	output logic                    strobe,
	output logic [STAMP_W-1:0]      out_stamp,
	output logic [CODE_W-1:0]       out_kind,
	output logic [CODE_W-1:0]       out_outcome,
	output logic [DUR_W-1:0]        out_duration,
	output logic [CODE_W-1:0]       out_origin,
	output logic                    record_valid,
	output logic                    last,
	output logic [COUNT_W-1:0]      stored_count
);

	q_stat_t q_stat;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	logic    q_not_empty;
	cmd_t    q_head;

	// command intake
	cel_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.event_stamp    (event_stamp),
		.event_kind     (event_kind),
		.outcome_code   (outcome_code),
		.event_duration (event_duration),
		.origin_code    (origin_code),
		.max_records    (max_records),
		.q_stat         (q_stat),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	// command queue
	cel_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.stat      (q_stat),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// ring and dump sequencer
	cel_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.pop          (pop),
		.strobe       (strobe),
		.out_stamp    (out_stamp),
		.out_kind     (out_kind),
		.out_outcome  (out_outcome),
		.out_duration (out_duration),
		.out_origin   (out_origin),
		.record_valid (record_valid),
		.last         (last),
		.stored_count (stored_count)
	);

endmodule : circular_event_log_top
`default_nettype wire
